FILE: design/efs_pkg.sv
// Package for the euclidean drum step sequencer: payload and queue types,
// register indexes, velocity constants, pattern tables and pulse-count helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package efs_pkg;

  // Pattern lengths. The pattern tables below are built for these lengths.
  localparam int unsigned BAR_STEPS   = 16;
  localparam int unsigned SNARE_STEPS = 8;
  localparam int unsigned BAR_W       = $clog2(BAR_STEPS);
  localparam int unsigned SNARE_W     = $clog2(SNARE_STEPS);

  // Queue between the classifier and the event emitter
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_DENSITY    = 3'd0,
    REG_COMPLEXITY = 3'd1,
    REG_KICK_NOTE  = 3'd2,
    REG_SNARE_NOTE = 3'd3,
    REG_CHAT_NOTE  = 3'd4,
    REG_OHAT_NOTE  = 3'd5
  } efs_reg_t;

  // Reset values of the registers
  localparam logic [10:0] DENSITY_RST    = 11'd512;
  localparam logic [10:0] COMPLEXITY_RST = 11'd512;
  localparam logic [6:0]  KICK_NOTE_RST  = 7'd36;
  localparam logic [6:0]  SNARE_NOTE_RST = 7'd38;
  localparam logic [6:0]  CHAT_NOTE_RST  = 7'd42;
  localparam logic [6:0]  OHAT_NOTE_RST  = 7'd46;

  // Q1.10 thresholds (strict float compares turned into >= on integers)
  localparam logic [10:0] SNARE_MIN_C = 11'd205;
  localparam logic [10:0] CHAT_MIN_D  = 11'd246;
  localparam logic [10:0] OHAT_MIN_C  = 11'd635;
  localparam logic [10:0] OHAT_MIN_D  = 11'd461;

  // Velocities
  localparam logic [6:0] VEL_KICK_ACC  = 7'd100;
  localparam logic [6:0] VEL_KICK      = 7'd78;
  localparam logic [6:0] VEL_CHAT_ACC  = 7'd58;
  localparam logic [6:0] VEL_CHAT      = 7'd38;
  localparam logic [6:0] VEL_OHAT      = 7'd62;
  localparam logic [6:0] VEL_SNARE_BASE = 7'd54;

  // Open hat steps
  localparam logic [BAR_W-1:0] OHAT_POS_A = BAR_W'(6);
  localparam logic [BAR_W-1:0] OHAT_POS_B = BAR_W'(14);

  // Bjorklund patterns by pulse count, bit i is step i
  localparam logic [BAR_STEPS-1:0] BAR_PAT [BAR_STEPS+1] = '{
    16'h0000, 16'h0001, 16'h0101, 16'h0421, 16'h1111, 16'h1249,
    16'h2929, 16'h54A9, 16'h5555, 16'h56AD, 16'hADAD, 16'hDB6D,
    16'hDDDD, 16'hF7BD, 16'hFDFD, 16'h7FFF, 16'hFFFF
  };
  localparam logic [SNARE_STEPS-1:0] SNARE_PAT [SNARE_STEPS+1] = '{
    8'h00, 8'h01, 8'h11, 8'h49, 8'h55, 8'h6D, 8'hDD, 8'h7F, 8'hFF
  };

  // Payload types
  typedef struct packed {
    logic [3:0]  step_pos;
    logic [15:0] sample_offset;
  } efs_in_t;

  typedef struct packed {
    logic [6:0]  note_number;
    logic [6:0]  velocity;
    logic [15:0] event_offset;
    logic        last_of_step;
  } efs_out_t;

  // One note event
  typedef struct packed {
    logic [6:0] note;
    logic [6:0] vel;
  } efs_ev_t;

  // Classified tick: one or two events
  typedef struct packed {
    logic        two_ev;
    efs_ev_t     ev0;
    efs_ev_t     ev1;
    logic [15:0] offset;
  } efs_cmd_t;

  // Queue status
  typedef struct packed {
    logic empty;
    logic full;
  } efs_qstat_t;

  // Settings and everything derived from them
  typedef struct packed {
    logic [6:0]             kick_note;
    logic [6:0]             snare_note;
    logic [6:0]             chat_note;
    logic [6:0]             ohat_note;
    logic [BAR_STEPS-1:0]   kick_pat;
    logic [SNARE_STEPS-1:0] snare_pat;
    logic [BAR_STEPS-1:0]   hat_pat;
    logic [3:0]             rot;
    logic [6:0]             snare_vel;
    logic                   snare_en;
    logic                   chat_en;
    logic                   ohat_en;
  } efs_cfg_t;

  // kick pulses = clamp(2 + floor(10d/1024), 1, BAR_STEPS)
  function automatic logic [4:0] kick_pulses(input logic [10:0] d);
    logic [14:0] m;
    logic [4:0]  s;
    m = 15'(d) * 15'd10;
    s = 5'(m >> 10) + 5'd2;
    return (s > 5'(BAR_STEPS)) ? 5'(BAR_STEPS) : s;
  endfunction

  // hat pulses = clamp(4 + floor(8d/1024), 2, BAR_STEPS)
  function automatic logic [4:0] hat_pulses(input logic [10:0] d);
    logic [4:0] s;
    s = 5'(d[10:7]) + 5'd4;
    return (s > 5'(BAR_STEPS)) ? 5'(BAR_STEPS) : s;
  endfunction

  // rotation = floor(5c/1024)
  function automatic logic [3:0] rotation(input logic [10:0] c);
    logic [13:0] m;
    m = 14'(c) * 14'd5;
    return 4'(m >> 10);
  endfunction

  // snare pulses = clamp(1 + rotation, 1, SNARE_STEPS)
  function automatic logic [3:0] snare_pulses(input logic [10:0] c);
    logic [4:0] s;
    s = 5'(rotation(c)) + 5'd1;
    return (s > 5'(SNARE_STEPS)) ? 4'(SNARE_STEPS) : 4'(s);
  endfunction

  // snare velocity = 54 + floor(36c/1024)
  function automatic logic [6:0] snare_velocity(input logic [10:0] c);
    logic [16:0] m;
    m = 17'(c) * 17'd36;
    return 7'(m >> 10) + VEL_SNARE_BASE;
  endfunction

endpackage

`default_nettype wire

FILE: design/euclidean_drum_step_sequencer.sv
// Top level of the euclidean drum step sequencer: settings, classifier,
// queue and event emitter. Depends on efs_pkg and the efs_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Each step tick (bar position and sample offset) is classified in the
// cycle it is accepted and yields zero to two note events, kick, snare,
// closed hat, open hat in that order. A tick can be accepted every cycle
// while the two-entry queue has room; the output register sends one event
// per cycle while out_stall is low, the two events of a tick one after the
// other. The first event of a tick passes through the queue and then the
// output register; a tick with no event produces nothing.
// Writes to density or complexity rebuild the kick, snare and hat patterns
// in the same edge, and ticks accepted from the next cycle on use them.
module euclidean_drum_step_sequencer import efs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [10:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire efs_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output efs_out_t         out_data
);

  efs_cfg_t   cfg;
  efs_qstat_t q_stat;
  efs_cmd_t   push_cmd, head;
  logic       push, pop;

  efs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  efs_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  efs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  efs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A first event taken is followed at once by the closing event of its tick
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last_of_step) |=>
      (out_valid && out_data.last_of_step))
    else $error("second event of a tick not presented next cycle");

  // A new output only comes out of a non-empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(q_stat.empty) == 1'b0))
    else $error("output raised with empty queue");

  // Queue fill count stays consistent
  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue both empty and full");

endmodule

`default_nettype wire

FILE: design/efs_cfg.sv
// Settings registers and the patterns and thresholds derived from them.
// Depends on efs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efs_cfg import efs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [10:0] cfg_wdata,
  output efs_cfg_t         cfg
);

  logic [10:0] density_r, density_nxt;
  logic [10:0] complexity_r, complexity_nxt;
  logic [6:0]  kick_note_r, kick_note_nxt;
  logic [6:0]  snare_note_r, snare_note_nxt;
  logic [6:0]  chat_note_r, chat_note_nxt;
  logic [6:0]  ohat_note_r, ohat_note_nxt;

  logic [BAR_STEPS-1:0]   kick_pat_r, hat_pat_r;
  logic [SNARE_STEPS-1:0] snare_pat_r;
  logic [3:0]             rot_r;
  logic [6:0]             snare_vel_r;
  logic                   snare_en_r, chat_en_r, ohat_en_r;

  // Register writes; reset values are forced here so derived state follows
  always_comb begin
    density_nxt    = density_r;
    complexity_nxt = complexity_r;
    kick_note_nxt  = kick_note_r;
    snare_note_nxt = snare_note_r;
    chat_note_nxt  = chat_note_r;
    ohat_note_nxt  = ohat_note_r;
    if (!rst_n) begin
      density_nxt    = DENSITY_RST;
      complexity_nxt = COMPLEXITY_RST;
      kick_note_nxt  = KICK_NOTE_RST;
      snare_note_nxt = SNARE_NOTE_RST;
      chat_note_nxt  = CHAT_NOTE_RST;
      ohat_note_nxt  = OHAT_NOTE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DENSITY:    density_nxt    = cfg_wdata;
        REG_COMPLEXITY: complexity_nxt = cfg_wdata;
        REG_KICK_NOTE:  kick_note_nxt  = cfg_wdata[6:0];
        REG_SNARE_NOTE: snare_note_nxt = cfg_wdata[6:0];
        REG_CHAT_NOTE:  chat_note_nxt  = cfg_wdata[6:0];
        REG_OHAT_NOTE:  ohat_note_nxt  = cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    density_r    <= density_nxt;
    complexity_r <= complexity_nxt;
    kick_note_r  <= kick_note_nxt;
    snare_note_r <= snare_note_nxt;
    chat_note_r  <= chat_note_nxt;
    ohat_note_r  <= ohat_note_nxt;
  end

  // Derived state, rebuilt in the same edge as the write
  always_ff @(posedge clk) begin
    kick_pat_r  <= BAR_PAT[kick_pulses(density_nxt)];
    hat_pat_r   <= BAR_PAT[hat_pulses(density_nxt)];
    snare_pat_r <= SNARE_PAT[snare_pulses(complexity_nxt)];
    rot_r       <= rotation(complexity_nxt);
    snare_vel_r <= snare_velocity(complexity_nxt);
    snare_en_r  <= (complexity_nxt >= SNARE_MIN_C);
    chat_en_r   <= (density_nxt >= CHAT_MIN_D);
    ohat_en_r   <= (complexity_nxt >= OHAT_MIN_C) && (density_nxt >= OHAT_MIN_D);
  end

  always_comb begin
    cfg.kick_note  = kick_note_r;
    cfg.snare_note = snare_note_r;
    cfg.chat_note  = chat_note_r;
    cfg.ohat_note  = ohat_note_r;
    cfg.kick_pat   = kick_pat_r;
    cfg.snare_pat  = snare_pat_r;
    cfg.hat_pat    = hat_pat_r;
    cfg.rot        = rot_r;
    cfg.snare_vel  = snare_vel_r;
    cfg.snare_en   = snare_en_r;
    cfg.chat_en    = chat_en_r;
    cfg.ohat_en    = ohat_en_r;
  end

endmodule

`default_nettype wire

FILE: design/efs_front.sv
// Front end: accepts step ticks and turns each into zero, one or two events.
// Depends on efs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efs_front import efs_pkg::*; (
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire efs_in_t    in_data,
  input  wire efs_cfg_t   cfg,
  input  wire efs_qstat_t q_stat,
  output logic            push,
  output efs_cmd_t        push_cmd
);

  logic [BAR_W-1:0]   p;
  logic [BAR_W-1:0]   kpos;
  logic [SNARE_W-1:0] spos;
  logic               kick, snare, chat, ohat;
  efs_ev_t            kick_ev, snare_ev, chat_ev, ohat_ev;

  // Room in the queue is the only thing that holds a tick back
  assign in_stall = q_stat.full;

  // Pattern lookups, rotation wraps by pattern length
  always_comb begin
    p    = in_data.step_pos[BAR_W-1:0];
    kpos = p - BAR_W'(cfg.rot);
    spos = p[BAR_W-1:1] - cfg.rot[SNARE_W-1:0];
  end

  // Which voices fire
  always_comb begin
    kick  = cfg.kick_pat[kpos];
    snare = cfg.snare_en && cfg.snare_pat[spos] && !p[0] && !kick;
    chat  = cfg.chat_en && cfg.hat_pat[p] && !kick && !snare;
    ohat  = cfg.ohat_en && ((p == OHAT_POS_A) || (p == OHAT_POS_B)) && !kick;
  end

  // Per-voice events
  always_comb begin
    kick_ev.note  = cfg.kick_note;
    kick_ev.vel   = (p[2:0] == 3'd0) ? VEL_KICK_ACC : VEL_KICK;
    snare_ev.note = cfg.snare_note;
    snare_ev.vel  = cfg.snare_vel;
    chat_ev.note  = cfg.chat_note;
    chat_ev.vel   = (p[1:0] == 2'd0) ? VEL_CHAT_ACC : VEL_CHAT;
    ohat_ev.note  = cfg.ohat_note;
    ohat_ev.vel   = VEL_OHAT;
  end

  // Kick stands alone; snare and closed hat exclude each other; open hat may follow
  always_comb begin
    push_cmd.offset = in_data.sample_offset;
    push_cmd.ev1    = ohat_ev;
    push_cmd.two_ev = (snare || chat) && ohat;
    if (kick) begin
      push_cmd.ev0 = kick_ev;
    end else if (snare) begin
      push_cmd.ev0 = snare_ev;
    end else if (chat) begin
      push_cmd.ev0 = chat_ev;
    end else begin
      push_cmd.ev0 = ohat_ev;
    end
    push = in_valid && !q_stat.full && (kick || snare || chat || ohat);
  end

endmodule

`default_nettype wire

FILE: design/efs_fifo.sv
// Short queue of classified ticks between the front end and the emitter.
// Depends on efs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efs_fifo import efs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire efs_cmd_t push_cmd,
  input  wire logic     pop,
  output efs_cmd_t      head,
  output efs_qstat_t    q_stat
);

  efs_cmd_t          ent_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = ent_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));

endmodule

`default_nettype wire

FILE: design/efs_back.sv
// Back end: plays out the one or two events of each queued tick through
// the output register. Depends on efs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module efs_back import efs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire efs_cmd_t   head,
  input  wire efs_qstat_t q_stat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output efs_out_t        out_data
);

  logic     out_valid_r, out_valid_nxt;
  efs_out_t out_data_r, out_data_nxt;
  logic     sel_r, sel_nxt;   // second event of the head is next
  logic     load_ok, ld, last;
  efs_ev_t  ev;

  // Load the output register whenever it is empty or being taken and the queue holds a tick
  always_comb begin
    load_ok = !out_valid_r || !out_stall;
    ld      = load_ok && !q_stat.empty;
    ev      = sel_r ? head.ev1 : head.ev0;
    last    = sel_r || !head.two_ev;
    pop     = ld && last;

    out_data_nxt.note_number  = ev.note;
    out_data_nxt.velocity     = ev.vel;
    out_data_nxt.event_offset = head.offset;
    out_data_nxt.last_of_step = last;

    sel_nxt       = ld ? !last : sel_r;
    out_valid_nxt = ld ? 1'b1 : (load_ok ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: dv/euclidean_drum_step_sequencer_tb.sv
// Testbench for euclidean_drum_step_sequencer: drives step ticks and settings, predicts
// the note events of each tick and checks them in order. Depends on efs_pkg and the RTL.
`timescale 1ns / 1ps

module euclidean_drum_step_sequencer_tb;
  import efs_pkg::*;

  localparam int unsigned CLK_HALF         = 4;
  localparam int unsigned TIMEOUT_CYCLES   = 400000;
  localparam int unsigned SETTLE_CYCLES    = 6;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned BURST_TICKS      = 24;
  localparam int unsigned RAND_PHASES      = 12;
  localparam int unsigned PHASE_TICKS      = 96;
  localparam int unsigned PRESSURE_PHASE   = 1;
  localparam int unsigned MAX_GAP          = 14;
  localparam int unsigned MAX_REPORTS      = 10;

  // Sequencer geometry, thresholds and velocities as the spec defines them
  localparam int unsigned STEPS_PER_BAR   = 16;
  localparam int unsigned SNARE_LEN       = 8;
  localparam int unsigned SNARE_ON_C      = 205;
  localparam int unsigned CHAT_ON_D       = 246;
  localparam int unsigned OHAT_ON_C       = 635;
  localparam int unsigned OHAT_ON_D       = 461;
  localparam int unsigned KICK_ACCENT_VEL = 100;
  localparam int unsigned KICK_PLAIN_VEL  = 78;
  localparam int unsigned CHAT_ACCENT_VEL = 58;
  localparam int unsigned CHAT_PLAIN_VEL  = 38;
  localparam int unsigned OHAT_VEL        = 62;
  localparam int unsigned SNARE_VEL_BASE  = 54;
  localparam int unsigned OHAT_STEP_A     = 6;
  localparam int unsigned OHAT_STEP_B     = 14;

  // Index past the register list; writes to it are ignored
  localparam logic [2:0] UNUSED_REG_IDX = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [10:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  efs_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  efs_out_t    out_data;

  bit          tx_idle;
  bit          rx_idle;
  bit          long_hold;
  int unsigned cycle_count = 0;

  // Predicts note events per tick and holds those still due
  class drum_event_predictor;
    logic [10:0] density;
    logic [10:0] complexity;
    logic [6:0]  kick_note;
    logic [6:0]  snare_note;
    logic [6:0]  chat_note;
    logic [6:0]  ohat_note;
    logic [63:0] kick_pat;
    logic [63:0] snare_pat;
    logic [63:0] hat_pat;
    efs_out_t    due_events[$];
    int unsigned bad_events;

    function new();
      density    = 11'd512;
      complexity = 11'd512;
      kick_note  = 7'd36;
      snare_note = 7'd38;
      chat_note  = 7'd42;
      ohat_note  = 7'd46;
      bad_events = 0;
      rebuild();
    endfunction

    // Append tail (tlen bits) after head (hlen bits)
    function logic [63:0] splice(logic [63:0] head, int unsigned hlen,
                                 logic [63:0] tail, int unsigned tlen);
      logic [63:0] r;
      int unsigned k;
      r = head;
      for (k = 0; k < tlen && hlen + k < 64; k++) r[hlen + k] = r[hlen + k] | tail[k];
      return r;
    endfunction

    // Bjorklund spreading of pulses over steps; remainder count kept as standard
    function logic [63:0] euclid(int unsigned pulses, int unsigned steps);
      logic [63:0] a, b, na, pat;
      int unsigned alen, blen, nalen, g, r, ng, i, pos;
      a = 64'd1;
      b = 64'd0;
      pat = 64'd0;
      alen = 1;
      blen = 1;
      pos = 0;
      if (pulses >= steps) return (64'd1 << steps) - 64'd1;
      if (pulses == 0) return 64'd0;
      g = pulses;
      r = steps - pulses;
      while (r > 1) begin
        if (r > g) begin
          a = splice(a, alen, b, blen);
          alen += blen;
          r -= g;
        end else begin
          na = splice(a, alen, b, blen);
          nalen = alen + blen;
          ng = r;
          b = a;
          blen = alen;
          r = g - r;
          a = na;
          alen = nalen;
          g = ng;
        end
      end
      for (i = 0; i < g; i++) begin
        pat = splice(pat, pos, a, alen);
        pos += alen;
      end
      for (i = 0; i < r; i++) begin
        pat = splice(pat, pos, b, blen);
        pos += blen;
      end
      return pat;
    endfunction

    function void rebuild();
      int unsigned d, c, kp, sp, hp;
      d = density;
      c = complexity;
      kp = 2 + (d * 10) / 1024;
      sp = 1 + (c * 5) / 1024;
      hp = 4 + (d * 8) / 1024;
      if (kp > STEPS_PER_BAR) kp = STEPS_PER_BAR;
      if (sp > SNARE_LEN) sp = SNARE_LEN;
      if (hp > STEPS_PER_BAR) hp = STEPS_PER_BAR;
      kick_pat  = euclid(kp, STEPS_PER_BAR);
      snare_pat = euclid(sp, SNARE_LEN);
      hat_pat   = euclid(hp, STEPS_PER_BAR);
    endfunction

    function void take_config(logic [2:0] idx, logic [10:0] val);
      case (idx)
        REG_DENSITY: begin
          density = val;
          rebuild();
        end
        REG_COMPLEXITY: begin
          complexity = val;
          rebuild();
        end
        REG_KICK_NOTE:  kick_note  = val[6:0];
        REG_SNARE_NOTE: snare_note = val[6:0];
        REG_CHAT_NOTE:  chat_note  = val[6:0];
        REG_OHAT_NOTE:  ohat_note  = val[6:0];
        default: ;
      endcase
    endfunction

    // Accepted tick request: queue the events it should cause
    function void take_tick(efs_in_t tick);
      int unsigned p, c, d, rot, kpos, spos, n, k;
      bit kick, snare, hat, ohat;
      logic [6:0] notes [4];
      logic [6:0] vels [4];
      efs_out_t ev;
      p = tick.step_pos;
      c = complexity;
      d = density;
      n = 0;
      rot  = (c * 5) / 1024;
      kpos = (p + STEPS_PER_BAR - rot % STEPS_PER_BAR) % STEPS_PER_BAR;
      spos = ((p / 2) % SNARE_LEN + SNARE_LEN - rot % SNARE_LEN) % SNARE_LEN;
      kick  = kick_pat[kpos];
      snare = c >= SNARE_ON_C && snare_pat[spos] && (p % 2) == 0;
      hat   = d >= CHAT_ON_D && hat_pat[p] && !kick;
      ohat  = c >= OHAT_ON_C && d >= OHAT_ON_D && (p == OHAT_STEP_A || p == OHAT_STEP_B);
      if (kick) begin
        notes[n] = kick_note;
        vels[n]  = (p == 0 || p == 8) ? 7'(KICK_ACCENT_VEL) : 7'(KICK_PLAIN_VEL);
        n++;
      end
      if (snare && !kick) begin
        notes[n] = snare_note;
        vels[n]  = 7'(SNARE_VEL_BASE + (c * 36) / 1024);
        n++;
      end
      if (hat && !snare) begin
        notes[n] = chat_note;
        vels[n]  = (p % 4 == 0) ? 7'(CHAT_ACCENT_VEL) : 7'(CHAT_PLAIN_VEL);
        n++;
      end
      if (ohat && !kick) begin
        notes[n] = ohat_note;
        vels[n]  = 7'(OHAT_VEL);
        n++;
      end
      if (n > 2) n = 2;
      for (k = 0; k < n; k++) begin
        ev.note_number  = notes[k];
        ev.velocity     = vels[k];
        ev.event_offset = tick.sample_offset;
        ev.last_of_step = (k == n - 1);
        due_events = {due_events, ev};
      end
    endfunction

    // Accepted event: compare with the oldest one due
    function void match_event(efs_out_t got);
      efs_out_t want;
      if (due_events.size() == 0) begin
        note_bad("event with none due", '0, got);
        return;
      end
      want = due_events.pop_front();
      if (got.note_number !== want.note_number || got.velocity !== want.velocity ||
          got.event_offset !== want.event_offset || got.last_of_step !== want.last_of_step)
        note_bad("event mismatch", want, got);
    endfunction

    function void note_bad(string what, efs_out_t want, efs_out_t got);
      bad_events++;
      if (bad_events <= MAX_REPORTS)
        $display({"%0t %s: want note %0d vel %0d off %0d last %0d,",
                  " got note %0d vel %0d off %0d last %0d"},
                 $time, what, want.note_number, want.velocity, want.event_offset,
                 want.last_of_step, got.note_number, got.velocity, got.event_offset,
                 got.last_of_step);
    endfunction
  endclass

  drum_event_predictor drum_events = new();

  euclidean_drum_step_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Observe both handshakes with pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) drum_events.take_tick(in_data);
      if (out_valid && !out_stall) drum_events.match_event(out_data);
    end
  end

  // Receiver: random stall per event, plus a long hold on request
  initial begin : rx_side
    int unsigned wait_n;
    out_stall = 1'b0;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        wait_n = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk);
        while (!(out_valid === 1'b1 && out_stall == 1'b0) && !long_hold);
      end
    end
  end

  // Offer one tick request after a random gap when tx_idle is set, return once accepted
  task automatic send_tick(input efs_in_t tick);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk);
    while (in_stall !== 1'b0);
  endtask

  function automatic efs_in_t random_tick();
    efs_in_t t;
    t.step_pos      = 4'($urandom_range(0, 15));
    t.sample_offset = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  // Write enable is left high; the caller lowers it after the batch
  task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    drum_events.take_config(idx, val);
  endtask

  task automatic apply_settings(input logic [10:0] d, input logic [10:0] c,
                                input logic [10:0] kn, input logic [10:0] sn,
                                input logic [10:0] chn, input logic [10:0] ohn);
    write_reg(REG_DENSITY, d);
    write_reg(REG_COMPLEXITY, c);
    write_reg(REG_KICK_NOTE, kn);
    write_reg(REG_SNARE_NOTE, sn);
    write_reg(REG_CHAT_NOTE, chn);
    write_reg(REG_OHAT_NOTE, ohn);
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait for every due event, then let silent ticks finish;
  // the wait starts at a clock edge so the last accepted tick is already predicted
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drum_events.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Threshold edges and saturation are favored over plain random levels
  function automatic logic [10:0] pick_density();
    case ($urandom_range(0, 10))
      0: return 11'd0;
      1: return 11'd245;
      2: return 11'd246;
      3: return 11'd460;
      4: return 11'd461;
      5: return 11'd1023;
      6: return 11'd1024;
      7: return 11'd1025;
      8: return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  function automatic logic [10:0] pick_complexity();
    case ($urandom_range(0, 10))
      0: return 11'd0;
      1: return 11'd204;
      2: return 11'd205;
      3: return 11'd634;
      4: return 11'd635;
      5: return 11'd1024;
      6: return 11'd1639;
      7: return 11'd1025;
      8: return 11'd2047;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // Wide values check that notes keep only their low bits
  function automatic logic [10:0] pick_note();
    return $urandom_range(0, 1) ? 11'($urandom_range(0, 127)) : 11'($urandom_range(0, 2047));
  endfunction

  initial begin : stimulus
    int unsigned ph, i;
    efs_in_t tick;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    tx_idle   = 1'b0;
    rx_idle   = 1'b0;
    long_hold = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Every bar position at reset settings, offset extremes first
    for (i = 0; i < STEPS_PER_BAR; i++) begin
      tick.step_pos = 4'(i);
      case (i)
        0: tick.sample_offset = 16'h0000;
        1: tick.sample_offset = 16'hFFFF;
        2: tick.sample_offset = 16'hAAAA;
        3: tick.sample_offset = 16'h5555;
        default: tick.sample_offset = 16'($urandom);
      endcase
      send_tick(tick);
    end
    settle();

    // Ignored index, then full density and complexity: open hats enabled
    write_reg(UNUSED_REG_IDX, 11'h7FF);
    apply_settings(11'd1024, 11'd1024, 11'd127, 11'd0, 11'h7FF, 11'd64);
    for (i = 0; i < STEPS_PER_BAR; i += 2) begin
      tick.step_pos      = 4'(i);
      tick.sample_offset = 16'($urandom);
      send_tick(tick);
    end
    settle();

    // Random phases, each with its own settings and idling mix
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)
        apply_settings(11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
      else if (ph == PRESSURE_PHASE)
        apply_settings(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
      else
        apply_settings(pick_density(), pick_complexity(), pick_note(), pick_note(),
                       pick_note(), pick_note());
      tx_idle = (ph > PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);
      rx_idle = (ph > PRESSURE_PHASE) && ($urandom_range(0, 3) != 0);

      // Receiver holds off while ticks keep coming, so the queue fills
      if (ph == PRESSURE_PHASE) begin
        long_hold = 1'b1;
        for (i = 0; i < BURST_TICKS; i++) send_tick(random_tick());
      end

      for (i = 0; i < PHASE_TICKS; i++) send_tick(random_tick());
      settle();
    end

    if (drum_events.due_events.size() != 0)
      $display("%0d events never arrived", drum_events.due_events.size());
    if (drum_events.bad_events == 0 && drum_events.due_events.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: euclidean_drum_step_sequencer.f
design/efs_pkg.sv
design/efs_cfg.sv
design/efs_front.sv
design/efs_fifo.sv
design/efs_back.sv
design/euclidean_drum_step_sequencer.sv
dv/euclidean_drum_step_sequencer_tb.sv
